// ===== design/sms_pkg.sv =====
// Shared types and fixed port widths of the sudoku Metropolis step block.
package sms_pkg;

  localparam int SITE_W       = 7;
  localparam int DIGIT_W      = 4;
  localparam int DRAW_W       = 16;
  localparam int LIMIT_W      = 17;
  localparam int DE_W         = 3;
  localparam int ENERGY_OUT_W = 8;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_ONE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_TWO   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_THREE = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_ONE_RESET   = 17'd2;
  localparam logic [LIMIT_W-1:0] LIMIT_TWO_RESET   = 17'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_THREE_RESET = 17'd0;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ROW,
    S_COL,
    S_BOX,
    S_READ,
    S_EVAL,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

// ===== design/sms_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sms_site_map.sv =====
// Three-stage pipeline that turns a cell index into its row, column and box.
module sms_site_map #(
  parameter int BOX_SIDE    = 3,
  parameter int DIGIT_COUNT = 9
) (
  input  logic                           clk,
  input  logic [sms_pkg::SITE_W-1:0]     site,
  output logic [$clog2(DIGIT_COUNT)-1:0] row,
  output logic [$clog2(DIGIT_COUNT)-1:0] col,
  output logic [$clog2(DIGIT_COUNT)-1:0] box
);

  localparam int RW      = $clog2(DIGIT_COUNT);
  localparam int SW      = sms_pkg::SITE_W;
  // Division by a constant is a multiplication by a rounded-up reciprocal.
  localparam int ROW_K   = SW + $clog2(DIGIT_COUNT);
  localparam int ROW_REC = (2 ** ROW_K + DIGIT_COUNT - 1) / DIGIT_COUNT;
  localparam int ROW_PW  = SW + ROW_K + 1;
  localparam int BOX_K   = RW + $clog2(BOX_SIDE);
  localparam int BOX_REC = (2 ** BOX_K + BOX_SIDE - 1) / BOX_SIDE;
  localparam int BOX_PW  = RW + BOX_K + 1;

  logic [ROW_PW-1:0] row_prod;
  logic [SW-1:0]     site1;
  logic [RW-1:0]     row1;
  logic [SW-1:0]     row_times;
  logic [BOX_PW-1:0] rb_prod;
  logic [RW-1:0]     row2;
  logic [RW-1:0]     col2;
  logic [RW-1:0]     rb2;
  logic [BOX_PW-1:0] cb_prod;
  logic [RW:0]       box_raw;

  assign row_prod  = ROW_PW'(site) * ROW_PW'(ROW_REC);
  assign row_times = SW'(row1) * SW'(DIGIT_COUNT);
  assign rb_prod   = BOX_PW'(row1) * BOX_PW'(BOX_REC);
  assign cb_prod   = BOX_PW'(col2) * BOX_PW'(BOX_REC);
  assign box_raw   = (RW+1)'(rb2) * (RW+1)'(BOX_SIDE) + (RW+1)'(cb_prod >> BOX_K);

  always_ff @(posedge clk) begin
    site1 <= site;
    row1  <= RW'(row_prod >> ROW_K);
    row2  <= row1;
    col2  <= RW'(site1 - row_times);
    rb2   <= RW'(rb_prod >> BOX_K);
    row   <= row2;
    col   <= col2;
    if (box_raw >= (RW+1)'(DIGIT_COUNT)) begin
      box <= RW'(box_raw - (RW+1)'(DIGIT_COUNT));
    end else begin
      box <= RW'(box_raw);
    end
  end

endmodule

// ===== design/sudoku_metropolis_step.sv =====
// Top level: sequencer for one Metropolis step on a sudoku grid held in RAM.
//
// An item is taken when start is high and busy is low. Its payload is the
// action (propose or force), the cell index, the proposed digit and a
// 16-bit random draw. Exactly one result word follows per item: done is
// high for one cycle and accepted, energy_change, old_digit and
// total_energy are valid in that cycle. The receiver cannot stall; the
// word is simply gone after that cycle.
// An item whose site or digit is out of range, or which proposes the digit
// already held, goes from the row and column states straight to the done
// state, with busy high throughout and done high in the last. Otherwise the
// six count words are read one per cycle through the single read port of
// the count RAM and, when accepted, written back one per cycle through its
// single write port. A new item may be started in the cycle after done.
// After reset the block sweeps both RAMs to their initial contents, one
// word per cycle, over all 2**(clog2(3*DIGIT_COUNT)+clog2(DIGIT_COUNT)) count
// RAM addresses (512 at the default size), with busy high. The limit registers may be
// written through the cfg channel at any time; cfg_ready is always high.
module sudoku_metropolis_step #(
  parameter int BOX_SIDE    = 3,
  parameter int DIGIT_COUNT = 9
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action,
  input  logic [sms_pkg::SITE_W-1:0]      site_index,
  input  logic [sms_pkg::DIGIT_W-1:0]     new_digit,
  input  logic [sms_pkg::DRAW_W-1:0]      random_draw,
  output logic                            done,
  output logic                            accepted,
  output logic signed [sms_pkg::DE_W-1:0] energy_change,
  output logic [sms_pkg::DIGIT_W-1:0]     old_digit,
  output logic [sms_pkg::ENERGY_OUT_W-1:0] total_energy,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sms_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sms_pkg::LIMIT_W-1:0]     cfg_data
);

  localparam int DW         = $clog2(DIGIT_COUNT);
  localparam int CLS_W      = $clog2(3 * DIGIT_COUNT);
  localparam int CNT_AW     = CLS_W + DW;
  localparam int CNT_DEPTH  = 2 ** CNT_AW;
  localparam int CNT_W      = $clog2(DIGIT_COUNT + 1);
  localparam int CELL_AW    = $clog2(DIGIT_COUNT * DIGIT_COUNT);
  localparam int CELL_DEPTH = 2 ** CELL_AW;
  localparam int CELL_COUNT = DIGIT_COUNT * DIGIT_COUNT;
  localparam int ENERGY_MAX = 3 * DIGIT_COUNT * (DIGIT_COUNT - 1);
  localparam int ENERGY_W   = $clog2(ENERGY_MAX + 1);
  localparam int DE_W       = sms_pkg::DE_W;

  sms_pkg::state_t state, state_next;

  logic [sms_pkg::LIMIT_W-1:0] limit_one, limit_two, limit_three;
  logic [CNT_AW-1:0]           clr_addr;
  logic [2:0]                  step;

  logic                        action_q;
  logic [sms_pkg::SITE_W-1:0]  site_q;
  logic [sms_pkg::DIGIT_W-1:0] nd_q;
  logic [sms_pkg::DRAW_W-1:0]  draw_q;
  logic [DW-1:0]               od_q;
  logic                        acc_q;
  logic signed [DE_W-1:0]      de_q;
  logic [ENERGY_W-1:0]         energy_q;
  logic [CNT_W-1:0]            cnt_od [3];
  logic [CNT_W-1:0]            cnt_nd [3];

  logic [DW-1:0]    row, col, box;
  logic [CLS_W-1:0] cls [3];
  logic             site_ok, site_ok_q, item_valid;

  logic              cell_we;
  logic [CELL_AW-1:0] cell_waddr, cell_raddr;
  logic [DW-1:0]     cell_wdata, cell_rdata;
  logic              cnt_we;
  logic [CNT_AW-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;

  logic [2:0]             cap_idx;
  logic [1:0]             rd_cls, wr_cls, cap_cls;
  logic signed [DE_W-1:0] de_sum;
  logic                   uphill_ok, acc_now;
  logic signed [ENERGY_W+1:0] energy_sum;
  logic [DW-1:0]          nd_dw;
  logic [CNT_W-1:0]       od_dec, nd_inc;

  sms_site_map #(
    .BOX_SIDE    (BOX_SIDE),
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_site_map (
    .clk  (clk),
    .site (site_q),
    .row  (row),
    .col  (col),
    .box  (box)
  );

  sms_ram #(.WIDTH(DW), .DEPTH(CELL_DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  sms_ram #(.WIDTH(CNT_W), .DEPTH(CNT_DEPTH)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  assign cls[0] = CLS_W'(row);
  assign cls[1] = CLS_W'(DIGIT_COUNT) + CLS_W'(col);
  assign cls[2] = CLS_W'(2 * DIGIT_COUNT) + CLS_W'(box);

  assign nd_dw   = DW'(nd_q);
  assign site_ok = 32'(site_index) < 32'(CELL_COUNT);
  assign item_valid = site_ok_q && (32'(nd_q) < 32'(DIGIT_COUNT))
                      && (32'(od_q) < 32'(DIGIT_COUNT)) && (32'(nd_q) != 32'(od_q));

  assign rd_cls  = step[2:1];
  assign wr_cls  = step[2:1];
  assign cap_idx = step - 3'd1;
  assign cap_cls = cap_idx[2:1];

  always_comb begin
    de_sum = '0;
    for (int i = 0; i < 3; i++) begin
      if (cnt_od[i] == CNT_W'(1)) begin
        de_sum = de_sum + DE_W'(1);
      end
      if (cnt_nd[i] == '0) begin
        de_sum = de_sum - DE_W'(1);
      end
    end
  end

  always_comb begin
    case (de_sum)
      DE_W'(1): uphill_ok = 17'(draw_q) <= limit_one;
      DE_W'(2): uphill_ok = 17'(draw_q) <= limit_two;
      default:  uphill_ok = 17'(draw_q) <= limit_three;
    endcase
  end

  assign acc_now    = action_q || (de_sum <= DE_W'(0)) || uphill_ok;
  assign energy_sum = (ENERGY_W+2)'(energy_q) + (ENERGY_W+2)'(de_sum);

  // Saturating updates of the count selected for the current write.
  assign od_dec = (cnt_od[wr_cls] == '0) ? '0 : cnt_od[wr_cls] - CNT_W'(1);
  assign nd_inc = (cnt_nd[wr_cls] == CNT_W'(DIGIT_COUNT)) ? cnt_nd[wr_cls]
                  : cnt_nd[wr_cls] + CNT_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      sms_pkg::S_CLEAR: begin
        if (clr_addr == '1) state_next = sms_pkg::S_IDLE;
      end
      sms_pkg::S_IDLE: begin
        if (start) state_next = sms_pkg::S_ROW;
      end
      sms_pkg::S_ROW: state_next = sms_pkg::S_COL;
      sms_pkg::S_COL: state_next = item_valid ? sms_pkg::S_BOX : sms_pkg::S_DONE;
      sms_pkg::S_BOX: state_next = sms_pkg::S_READ;
      sms_pkg::S_READ: begin
        if (step == 3'd6) state_next = sms_pkg::S_EVAL;
      end
      sms_pkg::S_EVAL: state_next = acc_now ? sms_pkg::S_WRITE : sms_pkg::S_DONE;
      sms_pkg::S_WRITE: begin
        if (step == 3'd5) state_next = sms_pkg::S_DONE;
      end
      sms_pkg::S_DONE: state_next = sms_pkg::S_IDLE;
      default: state_next = sms_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    busy       = (state != sms_pkg::S_IDLE);
    done       = (state == sms_pkg::S_DONE);
    cfg_ready  = 1'b1;
    cell_we    = 1'b0;
    cell_waddr = CELL_AW'(site_q);
    cell_wdata = nd_dw;
    cell_raddr = CELL_AW'(site_index);
    cnt_we     = 1'b0;
    cnt_waddr  = {cls[wr_cls], step[0] ? nd_dw : od_q};
    cnt_wdata  = step[0] ? nd_inc : od_dec;
    cnt_raddr  = {cls[rd_cls], step[0] ? nd_dw : od_q};
    case (state)
      sms_pkg::S_CLEAR: begin
        // Digit zero starts full in every class; the grid starts all zero.
        cnt_we     = 1'b1;
        cnt_waddr  = clr_addr;
        cnt_wdata  = (clr_addr[DW-1:0] == '0) ? CNT_W'(DIGIT_COUNT) : '0;
        cell_we    = (clr_addr[CNT_AW-1:CELL_AW] == '0);
        cell_waddr = clr_addr[CELL_AW-1:0];
        cell_wdata = '0;
      end
      sms_pkg::S_WRITE: begin
        cnt_we  = 1'b1;
        cell_we = (step == 3'd0);
      end
      default: begin
        cnt_we  = 1'b0;
        cell_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sms_pkg::S_CLEAR;
      clr_addr    <= '0;
      step        <= '0;
      limit_one   <= sms_pkg::LIMIT_ONE_RESET;
      limit_two   <= sms_pkg::LIMIT_TWO_RESET;
      limit_three <= sms_pkg::LIMIT_THREE_RESET;
      energy_q    <= ENERGY_W'(ENERGY_MAX);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sms_pkg::REG_LIMIT_ONE:   limit_one   <= cfg_data;
          sms_pkg::REG_LIMIT_TWO:   limit_two   <= cfg_data;
          sms_pkg::REG_LIMIT_THREE: limit_three <= cfg_data;
          default: ;
        endcase
      end
      if (state == sms_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + CNT_AW'(1);
      end
      if ((state == sms_pkg::S_READ || state == sms_pkg::S_WRITE) && state_next == state) begin
        step <= step + 3'd1;
      end else begin
        step <= '0;
      end
      if (state == sms_pkg::S_EVAL && acc_now) begin
        energy_q <= energy_sum[ENERGY_W+1] ? '0 : ENERGY_W'(energy_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == sms_pkg::S_IDLE && start) begin
      action_q  <= action;
      site_q    <= site_index;
      nd_q      <= new_digit;
      draw_q    <= random_draw;
      site_ok_q <= site_ok;
      acc_q     <= 1'b0;
      de_q      <= '0;
    end
    if (state == sms_pkg::S_ROW) begin
      od_q <= site_ok_q ? cell_rdata : '0;
    end
    if (state == sms_pkg::S_READ && step != 3'd0) begin
      if (cap_idx[0]) begin
        cnt_nd[cap_cls] <= cnt_rdata;
      end else begin
        cnt_od[cap_cls] <= cnt_rdata;
      end
    end
    if (state == sms_pkg::S_EVAL) begin
      de_q  <= de_sum;
      acc_q <= acc_now;
    end
  end

  assign accepted      = acc_q;
  assign energy_change = de_q;
  assign old_digit     = sms_pkg::DIGIT_W'(od_q);
  assign total_energy  = sms_pkg::ENERGY_OUT_W'(energy_q);

endmodule
